@@ rtl/rpt_pkg.sv @@
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types, constants and helpers for the rendezvous pair table.
// ----------------------------------------------------------------------------
package rpt_pkg;

   localparam int ENTRIES = 1024;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int SCAN_W  = IDX_W + 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam int MAX_PAIRS_W = 11;
   localparam int TIMEOUT_W   = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int REMOVED_W   = 11;

   localparam logic [MAX_PAIRS_W-1:0] MAX_PAIRS_RESET    = 11'd1000;
   localparam logic [TIMEOUT_W-1:0]   IDLE_TIMEOUT_RESET = 16'd60;

   localparam logic [47:0] ADDR_EMPTY = {32'hFFFF_FFFF, 16'h0000};

   typedef enum logic [0:0] {
      CSR_MAX_PAIRS    = 1'b0,
      CSR_IDLE_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_REQUEST = 2'd0,
      OP_CONFIRM = 2'd1,
      OP_TICK    = 2'd2,
      OP_SWEEP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CT_ONE_DIRECT  = 3'd0,
      CT_ONE_CONTROL = 3'd1,
      CT_ONE_ALT     = 3'd2,
      CT_TWO_DIRECT  = 3'd3,
      CT_TWO_CONTROL = 3'd4,
      CT_TWO_ALT     = 3'd5,
      CT_BAD_LOW     = 3'd6,
      CT_BAD_HIGH    = 3'd7
   } client_kind_type;

   typedef enum logic [3:0] {
      ST_RESPONSE   = 4'd0,
      ST_WAITING    = 4'd1,
      ST_FULL       = 4'd2,
      ST_STALE      = 4'd3,
      ST_BAD_CLIENT = 4'd4,
      ST_BAD_SIZE   = 4'd5,
      ST_CONF_HIT   = 4'd6,
      ST_CONF_MISS  = 4'd7,
      ST_TICK       = 4'd8,
      ST_SWEPT      = 4'd9
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        used;
      logic [63:0] id_high;
      logic [63:0] id_low;
      logic [47:0] s1_addr;
      logic [47:0] s1_alt;
      logic [47:0] s2_addr;
      logic [47:0] s2_alt;
      logic [31:0] s1_stamp;
      logic [31:0] s2_stamp;
      logic        s1_wants_alt;
      logic        s2_wants_alt;
      logic [31:0] seen;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      status_type            status;
      logic [31:0]           dest_ip;
      logic [15:0]           dest_port;
      logic [31:0]           answer_ip;
      logic [15:0]           answer_port;
      logic [31:0]           echo_stamp;
      logic [REMOVED_W-1:0]  removed_count;
      logic                  last;
   } res_type;

   function automatic logic addr_empty(input logic [47:0] a);
      return a[47:16] == 32'hFFFF_FFFF;
   endfunction

endpackage

@@ rtl/rpt_ram.sv @@
// ----------------------------------------------------------------------------
// rpt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rendezvous_pair_table.sv @@
// ----------------------------------------------------------------------------
// rendezvous_pair_table
// Link record table keyed by a 128-bit id, pairing two sides and answering
// both once all needed addresses are known; idle records are swept out.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake             payload
//   req_*     in          req_valid/req_ready   op, key, source, client, stamp
//   rsp_*     out         rsp_valid/rsp_ready   status, dest, answer, echo
//   csr_*     in          csr_write             csr_index, csr_wdata
//
// request, confirmation and sweep walk the record memory one entry a cycle,
//   set by the single read port of the ram
// tick and bad-size words skip the scan and go straight to decide
// after reset a clearing pass writes every entry before req_ready rises
// a held result sits in the output register while the next word is taken;
//   the next word then waits in its output stage until that result is taken
//
module rendezvous_pair_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_key_high,
   input  logic [63:0] req_key_low,
   input  logic [31:0] req_src_ip,
   input  logic [15:0] req_src_port,
   input  logic [2:0]  req_client_kind,
   input  logic [31:0] req_stamp,
   input  logic        req_size_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_dest_ip,
   output logic [15:0] rsp_dest_port,
   output logic [31:0] rsp_answer_ip,
   output logic [15:0] rsp_answer_port,
   output logic [31:0] rsp_echo_stamp,
   output logic [10:0] rsp_removed_count,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // control state
   rpt_pkg::state_type state_ff, state_in;
   logic [rpt_pkg::SCAN_W-1:0] scan_ff;
   logic                       rd_valid_ff;
   logic [rpt_pkg::IDX_W-1:0]  rd_idx_ff;
   logic [rpt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [31:0]                now_ff, now_in;
   logic [rpt_pkg::MAX_PAIRS_W-1:0] max_pairs_ff;
   logic [rpt_pkg::TIMEOUT_W-1:0]   timeout_ff;

   // latched word
   rpt_pkg::op_type op_ff;
   logic [63:0] key_hi_ff, key_lo_ff;
   logic [47:0] src_ff;
   logic [2:0]  ctype_ff;
   logic [31:0] stamp_ff;
   logic        size_ok_ff;

   // scan results
   logic                       found_ff, free_found_ff;
   logic [rpt_pkg::IDX_W-1:0]  match_idx_ff, free_idx_ff;
   rpt_pkg::rec_type           rec_ff;
   logic [rpt_pkg::CNT_W-1:0]  removed_ff;

   // pending and output results
   rpt_pkg::res_type pend0_ff, pend1_ff, pend0_in, pend1_in;
   logic             two_ff, two_in, second_ff;
   rpt_pkg::res_type rsp_ff;
   logic             rsp_valid_ff;

   // ram ports
   logic                       wr_en;
   logic [rpt_pkg::IDX_W-1:0]  wr_addr;
   logic [rpt_pkg::REC_W-1:0]  wr_data;
   logic [rpt_pkg::REC_W-1:0]  rd_data;
   rpt_pkg::rec_type           rd_rec;

   // decide-stage outputs
   logic                       dec_wr;
   logic [rpt_pkg::IDX_W-1:0]  dec_addr;
   rpt_pkg::rec_type           dec_rec;

   logic accept, rsp_load, scan_issue, scan_done;
   logic idle_hit, key_hit;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == rpt_pkg::S_IDLE);
   assign rsp_load  = (state_ff == rpt_pkg::S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign scan_issue = (state_ff == rpt_pkg::S_SCAN) &&
                       (scan_ff != rpt_pkg::SCAN_W'(rpt_pkg::ENTRIES));
   assign scan_done  = (state_ff == rpt_pkg::S_SCAN) && !scan_issue && !rd_valid_ff;

   assign rd_rec   = rpt_pkg::rec_type'(rd_data);
   assign idle_hit = rd_rec.used && ((now_ff - rd_rec.seen) > {16'b0, timeout_ff});
   assign key_hit  = rd_rec.used && (rd_rec.id_high == key_hi_ff) &&
                     (rd_rec.id_low == key_lo_ff);

   // record memory: every record field plus the used flag in one word
   rpt_ram #(
      .WIDTH(rpt_pkg::REC_W),
      .DEPTH(rpt_pkg::ENTRIES)
   ) u_rec_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(scan_ff[rpt_pkg::IDX_W-1:0]),
      .rd_data(rd_data)
   );

   // write port mux: clearing pass, sweep removal, decide write-back
   always_comb begin
      rpt_pkg::rec_type swept;
      swept      = rd_rec;
      swept.used = 1'b0;
      wr_en   = 1'b0;
      wr_addr = dec_addr;
      wr_data = dec_rec;
      case (state_ff)
         rpt_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[rpt_pkg::IDX_W-1:0];
            wr_data = '0;
         end
         rpt_pkg::S_SCAN: begin
            wr_en   = rd_valid_ff && (op_ff == rpt_pkg::OP_SWEEP) && idle_hit;
            wr_addr = rd_idx_ff;
            wr_data = swept;
         end
         rpt_pkg::S_DECIDE: begin
            wr_en = dec_wr;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // decide: build the new record and the results of the word
   always_comb begin
      rpt_pkg::rec_type fresh, r;
      rpt_pkg::res_type one;
      logic full, stale, side_one, side_two;
      fresh              = '0;
      fresh.used         = 1'b1;
      fresh.id_high      = key_hi_ff;
      fresh.id_low       = key_lo_ff;
      fresh.s1_addr      = rpt_pkg::ADDR_EMPTY;
      fresh.s1_alt       = rpt_pkg::ADDR_EMPTY;
      fresh.s2_addr      = rpt_pkg::ADDR_EMPTY;
      fresh.s2_alt       = rpt_pkg::ADDR_EMPTY;
      // new records start already idle
      fresh.seen         = now_ff - {16'b0, timeout_ff} - 32'd1;
      r        = found_ff ? rec_ff : fresh;
      full     = (32'(count_ff) >= 32'(max_pairs_ff)) || !free_found_ff;
      stale    = 1'b0;
      side_one = (ctype_ff <= rpt_pkg::CT_ONE_ALT);
      side_two = !side_one && (ctype_ff <= rpt_pkg::CT_TWO_ALT);
      one      = '0;
      one.last = 1'b1;

      dec_wr   = 1'b0;
      dec_addr = found_ff ? match_idx_ff : free_idx_ff;
      count_in = count_ff;
      now_in   = now_ff;
      two_in   = 1'b0;
      pend0_in = one;
      pend1_in = one;

      case (op_ff)
         rpt_pkg::OP_TICK: begin
            now_in          = now_ff + 32'd1;
            pend0_in.status = rpt_pkg::ST_TICK;
         end
         rpt_pkg::OP_SWEEP: begin
            count_in               = count_ff - removed_ff;
            pend0_in.status        = rpt_pkg::ST_SWEPT;
            pend0_in.removed_count = rpt_pkg::REMOVED_W'(removed_ff);
         end
         rpt_pkg::OP_CONFIRM: begin
            if (!size_ok_ff) begin
               pend0_in.status = rpt_pkg::ST_BAD_SIZE;
            end else if (found_ff) begin
               r.seen          = now_ff;
               dec_wr          = 1'b1;
               pend0_in.status = rpt_pkg::ST_CONF_HIT;
            end else begin
               pend0_in.status = rpt_pkg::ST_CONF_MISS;
            end
         end
         default: begin
            if (!size_ok_ff) begin
               pend0_in.status = rpt_pkg::ST_BAD_SIZE;
            end else if (!found_ff && full) begin
               pend0_in.status = rpt_pkg::ST_FULL;
            end else begin
               dec_wr = 1'b1;
               if (!found_ff) begin
                  count_in = count_ff + rpt_pkg::CNT_W'(1);
               end
               if (side_one) begin
                  stale = stamp_ff < r.s1_stamp;
                  if (!stale) begin
                     if ((!rpt_pkg::addr_empty(r.s1_addr) ||
                          !rpt_pkg::addr_empty(r.s1_alt)) && stamp_ff > r.s1_stamp) begin
                        r.s1_addr = rpt_pkg::ADDR_EMPTY;
                        r.s1_alt  = rpt_pkg::ADDR_EMPTY;
                        r.s2_addr = rpt_pkg::ADDR_EMPTY;
                        r.s2_alt  = rpt_pkg::ADDR_EMPTY;
                        r.s1_wants_alt = 1'b0;
                        r.s2_wants_alt = 1'b0;
                     end
                     if (ctype_ff == rpt_pkg::CT_ONE_ALT) begin
                        r.s1_alt = src_ff;
                     end else begin
                        r.s1_addr = src_ff;
                     end
                     r.s1_wants_alt = (ctype_ff != rpt_pkg::CT_ONE_DIRECT);
                     r.s1_stamp     = stamp_ff;
                  end
               end else if (side_two) begin
                  stale = stamp_ff < r.s2_stamp;
                  if (!stale) begin
                     if ((!rpt_pkg::addr_empty(r.s2_addr) ||
                          !rpt_pkg::addr_empty(r.s2_alt)) && stamp_ff > r.s2_stamp) begin
                        r.s1_addr = rpt_pkg::ADDR_EMPTY;
                        r.s1_alt  = rpt_pkg::ADDR_EMPTY;
                        r.s2_addr = rpt_pkg::ADDR_EMPTY;
                        r.s2_alt  = rpt_pkg::ADDR_EMPTY;
                        r.s1_wants_alt = 1'b0;
                        r.s2_wants_alt = 1'b0;
                     end
                     if (ctype_ff == rpt_pkg::CT_TWO_ALT) begin
                        r.s2_alt = src_ff;
                     end else begin
                        r.s2_addr = src_ff;
                     end
                     r.s2_wants_alt = (ctype_ff != rpt_pkg::CT_TWO_DIRECT);
                     r.s2_stamp     = stamp_ff;
                  end
               end

               if (!side_one && !side_two) begin
                  pend0_in.status = rpt_pkg::ST_BAD_CLIENT;
               end else if (stale) begin
                  pend0_in.status = rpt_pkg::ST_STALE;
               end else begin
                  r.seen = now_ff;
                  if (!rpt_pkg::addr_empty(r.s1_addr) && !rpt_pkg::addr_empty(r.s2_addr) &&
                      (!r.s1_wants_alt || !rpt_pkg::addr_empty(r.s1_alt)) &&
                      (!r.s2_wants_alt || !rpt_pkg::addr_empty(r.s2_alt))) begin
                     // first word toward side two, second toward side one
                     two_in = 1'b1;
                     pend0_in.status    = rpt_pkg::ST_RESPONSE;
                     pend0_in.last      = 1'b0;
                     {pend0_in.dest_ip, pend0_in.dest_port} = r.s2_addr;
                     {pend0_in.answer_ip, pend0_in.answer_port} =
                        r.s1_wants_alt ? r.s1_alt : r.s1_addr;
                     pend0_in.echo_stamp = r.s1_stamp;
                     pend1_in.status    = rpt_pkg::ST_RESPONSE;
                     {pend1_in.dest_ip, pend1_in.dest_port} = r.s1_addr;
                     {pend1_in.answer_ip, pend1_in.answer_port} =
                        r.s2_wants_alt ? r.s2_alt : r.s2_addr;
                     pend1_in.echo_stamp = r.s2_stamp;
                  end else begin
                     pend0_in.status = rpt_pkg::ST_WAITING;
                  end
               end
            end
         end
      endcase
      dec_rec = r;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpt_pkg::S_CLEAR: begin
            if (scan_ff == rpt_pkg::SCAN_W'(rpt_pkg::ENTRIES - 1)) begin
               state_in = rpt_pkg::S_IDLE;
            end
         end
         rpt_pkg::S_IDLE: begin
            if (accept) begin
               if (req_op == rpt_pkg::OP_TICK ||
                   ((req_op inside {rpt_pkg::OP_REQUEST, rpt_pkg::OP_CONFIRM}) &&
                    !req_size_ok)) begin
                  state_in = rpt_pkg::S_DECIDE;
               end else begin
                  state_in = rpt_pkg::S_SCAN;
               end
            end
         end
         rpt_pkg::S_SCAN: begin
            if (scan_done) begin
               state_in = rpt_pkg::S_DECIDE;
            end
         end
         rpt_pkg::S_DECIDE: begin
            state_in = rpt_pkg::S_OUT;
         end
         rpt_pkg::S_OUT: begin
            if (rsp_load && !(two_ff && !second_ff)) begin
               state_in = rpt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rpt_pkg::S_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpt_pkg::S_CLEAR;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         count_ff     <= '0;
         now_ff       <= '0;
         max_pairs_ff <= rpt_pkg::MAX_PAIRS_RESET;
         timeout_ff   <= rpt_pkg::IDLE_TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= scan_issue;
         if (state_ff == rpt_pkg::S_CLEAR || scan_issue) begin
            scan_ff <= scan_ff + rpt_pkg::SCAN_W'(1);
         end else if (accept) begin
            scan_ff <= '0;
         end
         if (state_ff == rpt_pkg::S_DECIDE) begin
            count_ff  <= count_in;
            now_ff    <= now_in;
            second_ff <= 1'b0;
         end
         if (csr_write) begin
            case (rpt_pkg::csr_index_type'(csr_index))
               rpt_pkg::CSR_MAX_PAIRS: begin
                  max_pairs_ff <= csr_wdata[rpt_pkg::MAX_PAIRS_W-1:0];
               end
               rpt_pkg::CSR_IDLE_TIMEOUT: begin
                  timeout_ff <= csr_wdata[rpt_pkg::TIMEOUT_W-1:0];
               end
               default: begin
                  timeout_ff <= timeout_ff;
               end
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            if (two_ff && !second_ff) begin
               second_ff <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // word, scan and result payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_ff[rpt_pkg::IDX_W-1:0];
      if (accept) begin
         op_ff         <= rpt_pkg::op_type'(req_op);
         key_hi_ff     <= req_key_high;
         key_lo_ff     <= req_key_low;
         src_ff        <= {req_src_ip, req_src_port};
         ctype_ff      <= req_client_kind;
         stamp_ff      <= req_stamp;
         size_ok_ff    <= req_size_ok;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         removed_ff    <= '0;
      end else if (state_ff == rpt_pkg::S_SCAN && rd_valid_ff) begin
         if (op_ff == rpt_pkg::OP_SWEEP) begin
            if (idle_hit) begin
               removed_ff <= removed_ff + rpt_pkg::CNT_W'(1);
            end
         end else begin
            if (key_hit && !found_ff) begin
               found_ff     <= 1'b1;
               match_idx_ff <= rd_idx_ff;
               rec_ff       <= rd_rec;
            end
            if (!rd_rec.used && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= rd_idx_ff;
            end
         end
      end
      if (state_ff == rpt_pkg::S_DECIDE) begin
         pend0_ff <= pend0_in;
         pend1_ff <= pend1_in;
         two_ff   <= two_in;
      end
      if (rsp_load) begin
         rsp_ff <= second_ff ? pend1_ff : pend0_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_dest_ip       = rsp_ff.dest_ip;
   assign rsp_dest_port     = rsp_ff.dest_port;
   assign rsp_answer_ip     = rsp_ff.answer_ip;
   assign rsp_answer_port   = rsp_ff.answer_port;
   assign rsp_echo_stamp    = rsp_ff.echo_stamp;
   assign rsp_removed_count = rsp_ff.removed_count;
   assign rsp_last          = rsp_ff.last;

   // record count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= rpt_pkg::ENTRIES)
      else $error("record count above table size");

   // no memory write while waiting for a word
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == rpt_pkg::S_IDLE |-> !wr_en)
      else $error("record write while idle");

   // only the first of a response pair lacks last
   a_last_pairing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> rsp_ff.status == rpt_pkg::ST_RESPONSE)
      else $error("non-final result that is not a response");

   // a tick advances the seconds counter by one
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == rpt_pkg::S_DECIDE && op_ff == rpt_pkg::OP_TICK |=>
      now_ff == $past(now_ff) + 32'd1)
      else $error("tick did not advance time");

endmodule
